>>> hw/rtl/assert_macros.svh
// Assertion macros for the compass gradient core.
// Used by the top level only; bodies fall away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CGT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CGT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CGT_ASSERT_IMP(label, ante, cons)
`define CGT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/cgt_pkg.sv
// Shared types, constants and arithmetic helpers of the compass gradient core.
// No dependencies.
package cgt_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int WIDTH_RST      = 640;
    localparam int HEIGHT_RST     = 480;
    localparam int MIN_DIM        = 3;
    localparam logic [7:0] THRESH_RST = 8'd64;

    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_IDX_THRESH = 2'd2;

    localparam logic [1:0] DIR_HORIZ = 2'd0;
    localparam logic [1:0] DIR_DIAG  = 2'd1;
    localparam logic [1:0] DIR_VERT  = 2'd2;
    localparam logic [1:0] DIR_ANTI  = 2'd3;

    localparam logic [9:0] DIV3_MUL = 10'd683;

    typedef struct packed {
        logic       edge_flag;
        logic [1:0] dir;
        logic [7:0] norm;
    } nrec_t;

    function automatic logic signed [10:0] ext(input logic [7:0] p);
        return signed'({3'b000, p});
    endfunction

    function automatic logic [9:0] abs10(input logic signed [10:0] v);
        logic signed [10:0] n;
        n = -v;
        return (v < 0) ? n[9:0] : v[9:0];
    endfunction

    // floor(a / 3) for a below 768, by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] a);
        logic [19:0] p;
        p = 20'(a) * 20'(DIV3_MUL);
        return p[18:11];
    endfunction

endpackage

>>> hw/rtl/compass_gradient_edge_thinning_core.sv
// An accepted word loads the result register directly, with the result of the pixel
// accepted 2*W+2 stream positions earlier; flush words drain the frame end. One word per
// clock unless m_tready stalls, set by the dual-port column memories read one step ahead.
// Reset (rst_n, asynchronous): stream position and output valid cleared,
// width 640, height 480, threshold 64. Line memories need no clearing.
`include "assert_macros.svh"

module compass_gradient_edge_thinning_core #(
    parameter int MAX_WIDTH  = cgt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cgt_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] cmd (flush)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] norm, [9:8] direction, [10] edge_res
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int LW = $clog2(MAX_HEIGHT + 3);
    localparam int W_RST = (cgt_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : cgt_pkg::WIDTH_RST;
    localparam int H_RST = (cgt_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : cgt_pkg::HEIGHT_RST;

    logic [WW-1:0]  w_eff_reg, w_eff_next;
    logic [LW-1:0]  h_eff_reg, h_eff_next;
    logic [7:0]     thr_reg, thr_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [LW-1:0]  line_reg, line_next;
    logic           out_valid_reg, out_valid_next;
    cgt_pkg::nrec_t out_rec_reg;
    logic           out_last_reg;

    logic [15:0]    pmem [MAX_WIDTH];
    cgt_pkg::nrec_t nmem [MAX_WIDTH];
    logic [15:0]    pix_rd_reg;
    cgt_pkg::nrec_t nrd_reg;
    logic [7:0]     win_reg [9];
    cgt_pkg::nrec_t l_reg, ul_reg, u_reg, ur_reg;

    logic           cfg_wr, restart, pixel_phase, step, interior, o_valid, o_last;
    logic [WW-1:0]  col_ext, col_p1, cn_p1;
    logic [CW-1:0]  col_p1m, col_m2, nrd_addr_next;
    logic [7:0]     k [9];
    logic signed [10:0] gx, gy, gd, gi;
    logic [7:0]     ax, ay, ad, ai, nrm, nn;
    logic [1:0]     dir;
    logic           cand, clr_sel, fwd;
    cgt_pkg::nrec_t q_rec, l_clr, ul_clr, u_clr, ur_clr, ur_in;
    logic [15:0]    pix_wr;
    logic [WW-1:0]  w_clamp;
    logic [LW-1:0]  h_clamp;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'b00000, out_rec_reg};
    assign m_tlast   = out_last_reg;

    always_comb
    begin
        if (cfg_data[10:0] < 11'(cgt_pkg::MIN_DIM))
            w_clamp = WW'(cgt_pkg::MIN_DIM);
        else if (cfg_data[10:0] > MAX_WIDTH)
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = WW'(cfg_data[10:0]);
        if (cfg_data < 13'(cgt_pkg::MIN_DIM))
            h_clamp = LW'(cgt_pkg::MIN_DIM);
        else if (cfg_data > MAX_HEIGHT)
            h_clamp = LW'(MAX_HEIGHT);
        else
            h_clamp = LW'(cfg_data);
    end

    always_comb
    begin
        pixel_phase = line_reg < h_eff_reg;
        step        = s_tvalid && s_tready && !(pixel_phase && s_tuser);
        interior    = (col_reg >= CW'(2)) && (line_reg >= LW'(2)) && pixel_phase;
        o_valid     = ((col_reg >= CW'(2)) && (line_reg >= LW'(2)))
                   || ((col_reg < CW'(2)) && (line_reg >= LW'(3)));
        o_last      = (col_reg == CW'(1)) && (line_reg == h_eff_reg + LW'(2));

        col_ext = WW'(col_reg);
        col_p1  = col_ext + WW'(1);
        col_p1m = (col_p1 == w_eff_reg) ? '0 : CW'(col_p1);
        col_m2  = (col_reg >= CW'(2)) ? CW'(col_ext - WW'(2))
                                      : CW'(col_ext + w_eff_reg - WW'(2));

        k[0] = win_reg[1];
        k[1] = win_reg[2];
        k[2] = pix_rd_reg[7:0];
        k[3] = win_reg[4];
        k[4] = win_reg[5];
        k[5] = pix_rd_reg[15:8];
        k[6] = win_reg[7];
        k[7] = win_reg[8];
        k[8] = s_tdata;
        pix_wr = {s_tdata, pix_rd_reg[15:8]};

        gx = cgt_pkg::ext(k[2]) + cgt_pkg::ext(k[5]) + cgt_pkg::ext(k[8])
           - cgt_pkg::ext(k[0]) - cgt_pkg::ext(k[3]) - cgt_pkg::ext(k[6]);
        gy = cgt_pkg::ext(k[6]) + cgt_pkg::ext(k[7]) + cgt_pkg::ext(k[8])
           - cgt_pkg::ext(k[0]) - cgt_pkg::ext(k[1]) - cgt_pkg::ext(k[2]);
        gd = cgt_pkg::ext(k[5]) + cgt_pkg::ext(k[2]) + cgt_pkg::ext(k[1])
           - cgt_pkg::ext(k[3]) - cgt_pkg::ext(k[6]) - cgt_pkg::ext(k[7]);
        gi = cgt_pkg::ext(k[5]) + cgt_pkg::ext(k[7]) + cgt_pkg::ext(k[8])
           - cgt_pkg::ext(k[1]) - cgt_pkg::ext(k[0]) - cgt_pkg::ext(k[3]);
        ax = cgt_pkg::div3(cgt_pkg::abs10(gx));
        ay = cgt_pkg::div3(cgt_pkg::abs10(gy));
        ad = cgt_pkg::div3(cgt_pkg::abs10(gd));
        ai = cgt_pkg::div3(cgt_pkg::abs10(gi));

        nrm = ax;
        dir = cgt_pkg::DIR_HORIZ;
        if (ay > nrm)
        begin
            nrm = ay;
            dir = cgt_pkg::DIR_VERT;
        end
        if (ad > nrm)
        begin
            nrm = ad;
            dir = cgt_pkg::DIR_DIAG;
        end
        if (ai > nrm)
        begin
            nrm = ai;
            dir = cgt_pkg::DIR_ANTI;
        end

        unique case (dir)
            cgt_pkg::DIR_HORIZ: nn = l_reg.norm;
            cgt_pkg::DIR_DIAG:  nn = ur_reg.norm;
            cgt_pkg::DIR_VERT:  nn = u_reg.norm;
            cgt_pkg::DIR_ANTI:  nn = ul_reg.norm;
            default:            nn = l_reg.norm;
        endcase

        cand    = interior && (nrm >= thr_reg);
        clr_sel = cand && (nrm > nn);
        q_rec.norm      = interior ? nrm : 8'd0;
        q_rec.dir       = interior ? dir : cgt_pkg::DIR_HORIZ;
        q_rec.edge_flag = cand && !(nrm < nn);

        l_clr  = l_reg;
        ur_clr = ur_reg;
        u_clr  = u_reg;
        ul_clr = ul_reg;
        if (clr_sel)
        begin
            unique case (dir)
                cgt_pkg::DIR_HORIZ: l_clr.edge_flag  = 1'b0;
                cgt_pkg::DIR_DIAG:  ur_clr.edge_flag = 1'b0;
                cgt_pkg::DIR_VERT:  u_clr.edge_flag  = 1'b0;
                cgt_pkg::DIR_ANTI:  ul_clr.edge_flag = 1'b0;
                default:            l_clr.edge_flag  = l_reg.edge_flag;
            endcase
        end

        fwd   = (col_m2 == col_p1m);
        ur_in = fwd ? l_clr : nrd_reg;

        restart = step && o_valid && o_last;
    end

    always_comb
    begin
        w_eff_next = w_eff_reg;
        h_eff_next = h_eff_reg;
        thr_next   = thr_reg;
        col_next   = col_reg;
        line_next  = line_reg;
        if (cfg_wr)
        begin
            if (cfg_index == cgt_pkg::CFG_IDX_WIDTH)
            begin
                w_eff_next = w_clamp;
                col_next   = '0;
                line_next  = '0;
            end
            else if (cfg_index == cgt_pkg::CFG_IDX_HEIGHT)
            begin
                h_eff_next = h_clamp;
                col_next   = '0;
                line_next  = '0;
            end
            else if (cfg_index == cgt_pkg::CFG_IDX_THRESH)
                thr_next = cfg_data[7:0];
        end
        else if (restart)
        begin
            col_next  = '0;
            line_next = '0;
        end
        else if (step)
        begin
            col_next = col_p1m;
            if (col_p1 == w_eff_reg)
                line_next = line_reg + LW'(1);
        end

        cn_p1         = WW'(col_next) + WW'(1);
        nrd_addr_next = (cn_p1 == w_eff_next) ? '0 : CW'(cn_p1);

        out_valid_next = out_valid_reg;
        if (step && o_valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg     <= WW'(W_RST);
            h_eff_reg     <= LW'(H_RST);
            thr_reg       <= cgt_pkg::THRESH_RST;
            col_reg       <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_eff_reg     <= w_eff_next;
            h_eff_reg     <= h_eff_next;
            thr_reg       <= thr_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pmem[col_reg] <= pix_wr;
            nmem[col_m2]  <= l_clr;
            win_reg       <= k;
            l_reg         <= q_rec;
            ul_reg        <= u_clr;
            u_reg         <= ur_clr;
            ur_reg        <= ur_in;
        end
        if (step && (col_reg == col_next))
            pix_rd_reg <= pix_wr;
        else
            pix_rd_reg <= pmem[col_next];
        if (step && (col_m2 == nrd_addr_next))
            nrd_reg <= l_clr;
        else
            nrd_reg <= nmem[nrd_addr_next];
        if (step && o_valid)
        begin
            out_rec_reg  <= ul_clr;
            out_last_reg <= o_last;
        end
    end

    `CGT_ASSERT_IMP(a_col_in_line, 1'b1, WW'(col_reg) < w_eff_reg)
    `CGT_ASSERT_IMP(a_line_bound, 1'b1, line_reg <= h_eff_reg + LW'(2))
    `CGT_ASSERT_NEXT(a_frame_restart, restart, col_reg == '0 && line_reg == '0)

endmodule
